// ----- src/packet_deframer_sum16_defines.svh -----
// Assertion helpers shared by the deframer modules.
`ifndef PACKET_DEFRAMER_SUM16_DEFINES_SVH
`define PACKET_DEFRAMER_SUM16_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PD16_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define PD16_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/pd16_pkg.sv -----
package pd16_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hA5;
   localparam logic [7:0] SYNC_SECOND = 8'h5A;
   localparam logic [7:0] END_FIRST   = 8'hCC;
   localparam logic [7:0] END_SECOND  = 8'h33;

   localparam logic [2:0] PH_HUNT1 = 3'd0;
   localparam logic [2:0] PH_HUNT2 = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_CHKHI = 3'd4;
   localparam logic [2:0] PH_CHKLO = 3'd5;
   localparam logic [2:0] PH_END1  = 3'd6;
   localparam logic [2:0] PH_END2  = 3'd7;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_PAYLOAD = 3'd1;
   localparam logic [2:0] EV_ACCEPT  = 3'd2;
   localparam logic [2:0] EV_BADSUM  = 3'd3;
   localparam logic [2:0] EV_BADEND  = 3'd4;
   localparam logic [2:0] EV_BADSYNC = 3'd5;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] frame_length;
   } pd16_rsp_type;

endpackage

// ----- src/packet_deframer_sum16.sv -----
// Byte-serial frame receiver with a 16-bit sum check.
// Slave channel (req_): one received byte per word in req_tdata[7:0].
// Master channel (rsp_): exactly one result word per accepted byte.
//   rsp_tuser carries the event (none, payload byte, frame accepted,
//   checksum mismatch, end byte error, sync error); rsp_tdata carries the
//   payload byte, its index and the accepted frame length, zero elsewhere.
// Frame: A5 5A, length, payload, checksum high, checksum low, CC 33.
// An empty buffer offers a byte's result in the cycle after the byte is taken.
// Throughput: one byte per cycle while req_tready is high; the frame state
//   updates in the same cycle that the byte is taken.
// A two-word output buffer sits behind the framer; req_tready comes from
//   its fill count, so one further byte is taken while a result waits.
//   If the receiver keeps rsp_tready low, req_tready drops once both words
//   are held and returns as soon as one is taken.
// Reset (synchronous, active high) empties the buffer and returns the
//   framer to hunting for the first start byte with all sums cleared.
module packet_deframer_sum16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                    // [23:16] frame_length
   output logic [2:0]  rsp_tuser    // [2:0] event_res
);
   import pd16_pkg::*;

   pd16_rsp_type framer_rsp;
   pd16_rsp_type head_rsp;
   logic         take;
   logic         full;

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   pd16_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_tdata),
      .rsp     (framer_rsp)
   );

   pd16_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (take),
      .wr_data  (framer_rsp),
      .full     (full),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (head_rsp)
   );

   assign rsp_tuser = head_rsp.event_res;
   assign rsp_tdata = {head_rsp.frame_length, head_rsp.payload_index,
                       head_rsp.payload_byte};

endmodule

// ----- src/pd16_framer.sv -----
`include "packet_deframer_sum16_defines.svh"

module pd16_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            rx_byte,
   output pd16_pkg::pd16_rsp_type rsp
);
   import pd16_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  expected_length_ff, expected_length_in;
   logic [7:0]  bytes_taken_ff, bytes_taken_in;
   logic [15:0] received_check_ff, received_check_in;
   logic        clear_frame;
   logic [7:0]  taken_next;

   assign taken_next = bytes_taken_ff + 8'd1;

   always_comb begin
      phase_in           = phase_ff;
      running_sum_in     = running_sum_ff;
      expected_length_in = expected_length_ff;
      bytes_taken_in     = bytes_taken_ff;
      received_check_in  = received_check_ff;
      clear_frame        = 1'b0;
      rsp                = '0;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT1: begin
               if (rx_byte == SYNC_FIRST) begin
                  running_sum_in = '0;
                  phase_in       = PH_HUNT2;
               end
            end
            PH_HUNT2: begin
               if (rx_byte == SYNC_SECOND) begin
                  phase_in = PH_LEN;
               end else begin
                  rsp.event_res = EV_BADSYNC;
                  clear_frame   = 1'b1;
               end
            end
            PH_LEN: begin
               running_sum_in     = running_sum_ff + {8'd0, rx_byte};
               expected_length_in = rx_byte;
               bytes_taken_in     = '0;
               phase_in           = (rx_byte == 8'd0) ? PH_CHKHI : PH_DATA;
            end
            PH_DATA: begin
               running_sum_in    = running_sum_ff + {8'd0, rx_byte};
               rsp.event_res     = EV_PAYLOAD;
               rsp.payload_byte  = rx_byte;
               rsp.payload_index = bytes_taken_ff;
               bytes_taken_in    = taken_next;
               if (taken_next >= expected_length_ff) begin
                  phase_in = PH_CHKHI;
               end
            end
            PH_CHKHI: begin
               received_check_in = {rx_byte, 8'd0};
               phase_in          = PH_CHKLO;
            end
            PH_CHKLO: begin
               received_check_in = {received_check_ff[15:8], rx_byte};
               phase_in          = PH_END1;
            end
            PH_END1: begin
               if (rx_byte == END_FIRST) begin
                  phase_in = PH_END2;
               end else begin
                  rsp.event_res = EV_BADEND;
                  clear_frame   = 1'b1;
               end
            end
            PH_END2: begin
               if (rx_byte != END_SECOND) begin
                  rsp.event_res = EV_BADEND;
               end else if (received_check_ff == running_sum_ff) begin
                  rsp.event_res    = EV_ACCEPT;
                  rsp.frame_length = expected_length_ff;
               end else begin
                  rsp.event_res = EV_BADSUM;
               end
               clear_frame = 1'b1;
            end
            default: begin
               clear_frame = 1'b1;
            end
         endcase
         if (clear_frame) begin
            phase_in           = PH_HUNT1;
            running_sum_in     = '0;
            expected_length_in = '0;
            bytes_taken_in     = '0;
            received_check_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HUNT1;
         running_sum_ff     <= '0;
         expected_length_ff <= '0;
         bytes_taken_ff     <= '0;
         received_check_ff  <= '0;
      end else begin
         phase_ff           <= phase_in;
         running_sum_ff     <= running_sum_in;
         expected_length_ff <= expected_length_in;
         bytes_taken_ff     <= bytes_taken_in;
         received_check_ff  <= received_check_in;
      end
   end

   `PD16_ASSERT_NOW(a_payload_in_data, take && rsp.event_res == EV_PAYLOAD,
      phase_ff == PH_DATA, "payload word outside data phase")
   `PD16_ASSERT_NOW(a_index_in_range, phase_ff == PH_DATA,
      bytes_taken_ff < expected_length_ff, "payload index beyond length")
   `PD16_ASSERT_NEXT(a_end_clears, take && (rsp.event_res == EV_ACCEPT ||
      rsp.event_res == EV_BADSUM || rsp.event_res == EV_BADEND ||
      rsp.event_res == EV_BADSYNC), phase_ff == PH_HUNT1 && running_sum_ff == 16'd0,
      "frame state not cleared after frame end")

endmodule

// ----- src/pd16_skid.sv -----
`include "packet_deframer_sum16_defines.svh"

module pd16_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  pd16_pkg::pd16_rsp_type wr_data,
   output logic                   full,
   output logic                   rd_valid,
   input  logic                   rd_ready,
   output pd16_pkg::pd16_rsp_type rd_data
);
   import pd16_pkg::*;

   pd16_rsp_type head_ff, head_in;
   pd16_rsp_type tail_ff, tail_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;

   assign pop      = rd_valid && rd_ready;
   assign full     = (count_ff == 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({wr_en, pop})
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = wr_data;
            end else begin
               head_in = tail_ff;
               tail_in = wr_data;
            end
         end
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = wr_data;
            end else begin
               tail_in = wr_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `PD16_ASSERT_NOW(a_no_overflow, wr_en, count_ff != 2'd2, "write into full buffer")
   `PD16_ASSERT_NEXT(a_drain, pop && !wr_en && count_ff == 2'd1, count_ff == 2'd0,
      "buffer did not drain")

endmodule

// ----- tb/pd16_checker.sv -----
`timescale 1ns / 100ps

module pd16_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          fail_count,
   output int          outstanding
);
   import pd16_pkg::*;

   pd16_rsp_type expected_events[$];

   logic [2:0]  frame_phase;
   logic [15:0] sum_acc;
   logic [7:0]  frame_len;
   logic [7:0]  bytes_seen;
   logic [15:0] rx_check;

   function automatic void clear_frame();
      frame_phase = PH_HUNT1;
      sum_acc     = '0;
      frame_len   = '0;
      bytes_seen  = '0;
      rx_check    = '0;
   endfunction

   function automatic pd16_rsp_type deframe_byte(input logic [7:0] b);
      pd16_rsp_type r;
      r = '0;
      r.event_res = EV_NONE;
      case (frame_phase)
         PH_HUNT1: begin
            if (b == SYNC_FIRST) begin
               sum_acc     = '0;
               frame_phase = PH_HUNT2;
            end
         end
         PH_HUNT2: begin
            if (b == SYNC_SECOND) begin
               frame_phase = PH_LEN;
            end else begin
               r.event_res = EV_BADSYNC;
               clear_frame();
            end
         end
         PH_LEN: begin
            sum_acc     = sum_acc + {8'h00, b};
            frame_len   = b;
            bytes_seen  = '0;
            frame_phase = (b == 8'h00) ? PH_CHKHI : PH_DATA;
         end
         PH_DATA: begin
            sum_acc         = sum_acc + {8'h00, b};
            r.event_res     = EV_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = bytes_seen;
            bytes_seen      = bytes_seen + 8'd1;
            if (bytes_seen >= frame_len) begin
               frame_phase = PH_CHKHI;
            end
         end
         PH_CHKHI: begin
            rx_check    = {b, 8'h00};
            frame_phase = PH_CHKLO;
         end
         PH_CHKLO: begin
            rx_check[7:0] = b;
            frame_phase   = PH_END1;
         end
         PH_END1: begin
            if (b == END_FIRST) begin
               frame_phase = PH_END2;
            end else begin
               r.event_res = EV_BADEND;
               clear_frame();
            end
         end
         default: begin
            if (b != END_SECOND) begin
               r.event_res = EV_BADEND;
            end else if (rx_check == sum_acc) begin
               r.event_res    = EV_ACCEPT;
               r.frame_length = frame_len;
            end else begin
               r.event_res = EV_BADSUM;
            end
            clear_frame();
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count  = 0;
      outstanding = 0;
      clear_frame();
   end

   always @(posedge clock) begin
      pd16_rsp_type want;
      if (reset) begin
         clear_frame();
         expected_events.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               $error("result word with no byte pending: event %0d data %h",
                      rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               compare_field("event_res", {5'b0, want.event_res}, {5'b0, rsp_tuser});
               compare_field("payload_byte", want.payload_byte, rsp_tdata[7:0]);
               compare_field("payload_index", want.payload_index, rsp_tdata[15:8]);
               compare_field("frame_length", want.frame_length, rsp_tdata[23:16]);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_events.push_back(deframe_byte(req_tdata));
         end
      end
      outstanding = expected_events.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import pd16_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLDOFF_LEN   = 80;
   localparam int TARGET_BYTES  = 800;

   typedef enum int {
      FR_GOOD,
      FR_BADSUM,
      FR_BADEND1,
      FR_BADEND2,
      FR_BADSYNC,
      FR_NOISE
   } frame_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int fail_count;
   int outstanding;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;
   int holdoff_asked = 0;
   int holdoff_given = 0;
   int holdoff_left  = 0;
   bit idle_on       = 1'b1;

   always #5 clock = ~clock;

   packet_deframer_sum16 u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pd16_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // hold the receiver off long on request, else stall at random if idle_on
   always @(negedge clock) begin
      if (holdoff_left != 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!reset && holdoff_asked > holdoff_given) begin
         rsp_tready    <= 1'b0;
         holdoff_left  <= HOLDOFF_LEN;
         holdoff_given <= holdoff_given + 1;
      end else begin
         rsp_tready <= idle_on ? ($urandom_range(99) >= 35) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic logic [7:0] other_than(input logic [7:0] avoid);
      logic [7:0] b;
      do begin
         b = 8'($urandom);
      end while (b == avoid);
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (idle_on && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned len, input frame_kind_type kind);
      logic [15:0] sum;
      logic [7:0]  b;
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         return;
      end
      send_byte(SYNC_FIRST);
      if (kind == FR_BADSYNC) begin
         send_byte(other_than(SYNC_SECOND));
         return;
      end
      send_byte(SYNC_SECOND);
      send_byte(len[7:0]);
      sum = 16'(len);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom);
         sum = sum + {8'h00, b};
         send_byte(b);
      end
      if (kind == FR_BADSUM) begin
         sum = sum ^ 16'($urandom_range(1, 65535));
      end
      send_byte(sum[15:8]);
      send_byte(sum[7:0]);
      if (kind == FR_BADEND1) begin
         send_byte(other_than(END_FIRST));
         return;
      end
      send_byte(END_FIRST);
      send_byte((kind == FR_BADEND2) ? other_than(END_SECOND) : END_SECOND);
   endtask

   task automatic send_random_frame();
      int unsigned len;
      int unsigned pick;
      frame_kind_type kind;
      len  = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      pick = $urandom_range(99);
      if (pick < 60)      kind = FR_GOOD;
      else if (pick < 70) kind = FR_BADSUM;
      else if (pick < 77) kind = FR_BADEND1;
      else if (pick < 84) kind = FR_BADEND2;
      else if (pick < 92) kind = FR_BADSYNC;
      else                kind = FR_NOISE;
      send_frame(len, kind);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do begin
         @(negedge clock);
      end while (outstanding != 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // stray bytes while hunting, then broken start pairs
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_SECOND);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_frame(0, FR_GOOD);
      send_frame(1, FR_GOOD);

      while (bytes_sent < 150) send_random_frame();
      holdoff_asked = holdoff_asked + 1;
      while (bytes_sent < 300) send_random_frame();

      idle_on = 1'b0;
      while (bytes_sent < 420) send_random_frame();
      idle_on = 1'b1;

      drain();
      send_frame(255, FR_GOOD);

      holdoff_asked = holdoff_asked + 1;
      while (bytes_sent < TARGET_BYTES) send_random_frame();

      drain();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
